[rtl/tagged_value_stream_decoder_macros.svh]
// assertion macros shared by the decoder's rtl files
`ifndef TAGGED_VALUE_STREAM_DECODER_MACROS_SVH
`define TAGGED_VALUE_STREAM_DECODER_MACROS_SVH

// condition holds at every clock edge out of reset
`define TVSD_ASSERT_ALWAYS(label, clk_sig, rst_sig, cond) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (cond)) \
		else $error("tvsd: invariant violated");

// consequent holds in the same cycle as the antecedent
`define TVSD_ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error("tvsd: implication violated");

`endif

[rtl/tvsd_pkg.sv]
`default_nettype none

package tvsd_pkg;

	// result kinds
	localparam logic [3:0] KIND_U8      = 4'd0;
	localparam logic [3:0] KIND_U16     = 4'd1;
	localparam logic [3:0] KIND_S32     = 4'd2;
	localparam logic [3:0] KIND_SMALL   = 4'd3;
	localparam logic [3:0] KIND_FALSE   = 4'd4;
	localparam logic [3:0] KIND_TRUE    = 4'd5;
	localparam logic [3:0] KIND_STRING  = 4'd6;
	localparam logic [3:0] KIND_UNKNOWN = 4'd7;
	localparam logic [3:0] KIND_TRUNC   = 4'd8;

	// tag bytes and masks
	localparam logic [7:0] TAG_U8     = 8'h04;
	localparam logic [7:0] TAG_U16    = 8'h05;
	localparam logic [7:0] TAG_S32    = 8'h07;
	localparam logic [7:0] TAG_STRING = 8'hC0;
	localparam logic [7:0] TAG_SMALL  = 8'h80;
	localparam logic [7:0] TAG_FALSE  = 8'h00;
	localparam logic [7:0] TAG_TRUE   = 8'h01;
	localparam logic [7:0] LEN_MASK   = 8'h3F;

	// configuration register indexes
	localparam logic CFG_HEADER_ENTRIES = 1'b0;
	localparam logic CFG_MAP_ENTRIES    = 1'b1;

	localparam logic [7:0]  HEADER_ENTRIES_RESET = 8'd19;
	localparam logic [15:0] MAP_ENTRIES_RESET    = 16'd160;
	localparam logic [15:0] COUNT_MAX            = 16'hFFFF;

	localparam int QUEUE_DEPTH = 2;

	// one decoded element on its way from front to back
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [15:0] num;
		logic        last;
	} evt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

[rtl/tvsd_in_if.sv]
`default_nettype none

interface tvsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/tvsd_out_if.sv]
`default_nettype none

interface tvsd_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         kind;
	logic signed [31:0] value;
	logic [15:0]        element_number;
	logic               in_map;
	logic               packet_end;

	modport source (output valid, output kind, output value, output element_number,
		output in_map, output packet_end, input ready);
	modport sink (input valid, input kind, input value, input element_number,
		input in_map, input packet_end, output ready);
endinterface

`default_nettype wire

[rtl/tvsd_front.sv]
`default_nettype none
`include "tagged_value_stream_decoder_macros.svh"

module tvsd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tvsd_in_if.sink                in_ch,
	input  wire tvsd_pkg::q_stat_t q_stat,
	output logic                   push,
	output tvsd_pkg::evt_t         evt
);

	logic [5:0]  left_q;
	logic [2:0]  pend_q;
	logic [31:0] acc_q;
	logic [15:0] cnt_q;
	logic        stopped_q;

	logic        hit;
	logic [7:0]  b;
	logic [3:0]  dec_kind;
	logic [5:0]  dec_need;
	logic [31:0] dec_val;
	logic [5:0]  left_n;
	logic [31:0] acc_n;
	logic [15:0] num;
	logic        emit;
	logic [3:0]  emit_kind;
	logic [31:0] emit_val;

	assign in_ch.ready = !q_stat.full;
	assign hit = in_ch.valid && in_ch.ready;
	assign b   = in_ch.data_byte;
	assign num = (cnt_q == tvsd_pkg::COUNT_MAX) ? tvsd_pkg::COUNT_MAX : cnt_q + 16'd1;
	assign left_n = left_q - 6'd1;
	assign acc_n = ({1'b0, pend_q} == tvsd_pkg::KIND_STRING) ? acc_q : {acc_q[23:0], b};

	// tag classification
	always_comb begin
		dec_kind = tvsd_pkg::KIND_UNKNOWN;
		dec_need = 6'd0;
		dec_val  = 32'd0;
		if (b == tvsd_pkg::TAG_U8) begin
			dec_kind = tvsd_pkg::KIND_U8;
			dec_need = 6'd1;
		end else if (b == tvsd_pkg::TAG_U16) begin
			dec_kind = tvsd_pkg::KIND_U16;
			dec_need = 6'd2;
		end else if (b == tvsd_pkg::TAG_S32) begin
			dec_kind = tvsd_pkg::KIND_S32;
			dec_need = 6'd4;
		end else if ((b & tvsd_pkg::TAG_STRING) == tvsd_pkg::TAG_STRING) begin
			dec_kind = tvsd_pkg::KIND_STRING;
			dec_need = b[5:0];
			dec_val  = {26'd0, b[5:0]};
		end else if ((b & tvsd_pkg::TAG_SMALL) == tvsd_pkg::TAG_SMALL) begin
			dec_kind = tvsd_pkg::KIND_SMALL;
			dec_val  = {24'd0, b & tvsd_pkg::LEN_MASK};
		end else if (b == tvsd_pkg::TAG_FALSE) begin
			dec_kind = tvsd_pkg::KIND_FALSE;
		end else if (b == tvsd_pkg::TAG_TRUE) begin
			dec_kind = tvsd_pkg::KIND_TRUE;
			dec_val  = 32'd1;
		end
	end

	// does this byte finish an element
	always_comb begin
		emit      = 1'b0;
		emit_kind = tvsd_pkg::KIND_TRUNC;
		emit_val  = 32'd0;
		if (stopped_q) begin
			emit = 1'b0;
		end else if (left_q != 6'd0) begin
			if (left_n == 6'd0) begin
				emit      = 1'b1;
				emit_kind = {1'b0, pend_q};
				emit_val  = acc_n;
			end else if (in_ch.last_byte) begin
				emit = 1'b1;
			end
		end else begin
			if (dec_need == 6'd0) begin
				emit      = 1'b1;
				emit_kind = dec_kind;
				emit_val  = dec_val;
			end else if (in_ch.last_byte) begin
				emit = 1'b1;
			end
		end
	end

	assign push       = hit && emit;
	assign evt.kind   = emit_kind;
	assign evt.value  = emit_val;
	assign evt.num    = num;
	assign evt.last   = in_ch.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= 6'd0;
			pend_q    <= 3'd0;
			acc_q     <= 32'd0;
			cnt_q     <= 16'd0;
			stopped_q <= 1'b0;
		end else if (hit) begin
			if (in_ch.last_byte) begin
				left_q    <= 6'd0;
				pend_q    <= 3'd0;
				acc_q     <= 32'd0;
				cnt_q     <= 16'd0;
				stopped_q <= 1'b0;
			end else begin
				if (emit) begin
					cnt_q <= num;
				end
				if (!stopped_q) begin
					if (left_q != 6'd0) begin
						left_q <= left_n;
						acc_q  <= acc_n;
					end else if (dec_need == 6'd0) begin
						if (dec_kind == tvsd_pkg::KIND_UNKNOWN) begin
							stopped_q <= 1'b1;
						end
					end else begin
						pend_q <= dec_kind[2:0];
						left_q <= dec_need;
						acc_q  <= dec_val;
					end
				end
			end
		end
	end

	`TVSD_ASSERT_IMPLIES(a_stop_no_pending, clk, arst_n, stopped_q, left_q == 6'd0)
	`TVSD_ASSERT_IMPLIES(a_pending_not_trunc, clk, arst_n, left_q != 6'd0,
		{1'b0, pend_q} != tvsd_pkg::KIND_UNKNOWN)

endmodule

`default_nettype wire

[rtl/tvsd_queue.sv]
`default_nettype none
`include "tagged_value_stream_decoder_macros.svh"

// small fifo between front and back, depth two or more
module tvsd_queue #(
	parameter int DEPTH = tvsd_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tvsd_pkg::evt_t push_data,
	input  wire logic           pop,
	output tvsd_pkg::evt_t      head,
	output tvsd_pkg::q_stat_t   stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tvsd_pkg::evt_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == CW'(0));
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`TVSD_ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push, !stat.full)
	`TVSD_ASSERT_ALWAYS(a_cnt_in_range, clk, arst_n, cnt_q <= CW'(DEPTH))

endmodule

`default_nettype wire

[rtl/tvsd_back.sv]
`default_nettype none
`include "tagged_value_stream_decoder_macros.svh"

module tvsd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire tvsd_pkg::evt_t    head,
	input  wire tvsd_pkg::q_stat_t q_stat,
	output logic                   pop,
	tvsd_out_if.source             out_ch
);

	logic [7:0]  hdr_q;
	logic [15:0] map_q;
	logic        out_valid_q;
	logic [3:0]  kind_q;
	logic [31:0] value_q;
	logic [15:0] num_q;
	logic        in_map_q;
	logic        last_q;

	logic [16:0] num_x;
	logic [16:0] hdr_x;
	logic [16:0] hi_x;
	logic        in_map;

	// window check: header < num <= header + map
	assign num_x  = {1'b0, head.num};
	assign hdr_x  = {9'd0, hdr_q};
	assign hi_x   = hdr_x + {1'b0, map_q};
	assign in_map = (num_x > hdr_x) && (num_x <= hi_x);

	assign pop = !q_stat.empty && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= tvsd_pkg::HEADER_ENTRIES_RESET;
			map_q <= tvsd_pkg::MAP_ENTRIES_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tvsd_pkg::CFG_HEADER_ENTRIES: hdr_q <= cfg_data[7:0];
				tvsd_pkg::CFG_MAP_ENTRIES:    map_q <= cfg_data;
				default:                      hdr_q <= hdr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head.kind;
			value_q  <= head.value;
			num_q    <= head.num;
			in_map_q <= in_map;
			last_q   <= head.last;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.kind           = kind_q;
	assign out_ch.value          = $signed(value_q);
	assign out_ch.element_number = num_q;
	assign out_ch.in_map         = in_map_q;
	assign out_ch.packet_end     = last_q;

	`TVSD_ASSERT_IMPLIES(a_in_map_numbered, clk, arst_n, out_valid_q && in_map_q,
		num_q != 16'd0)

endmodule

`default_nettype wire

[rtl/tagged_value_stream_decoder.sv]
`default_nettype none

// Tagged value stream decoder. Payload bytes of one packet at a time enter on
// in_ch, one byte per cycle, with last_byte on the final byte. Each completed
// element (u8, u16, s32, 6-bit small, false, true, skipped string, unknown tag,
// or a truncation when the packet ends inside an element) gives one item on
// out_ch with its kind, value, 1-based element number and an in_map flag for
// header_entries < number <= header_entries + map_entries. After an unknown tag
// the rest of the packet is dropped. Sustained rate is one byte per cycle in
// and one result per cycle out; a byte is taken whenever the front-to-back
// queue has room, so input stalls only while out_ch holds back results. A result
// is written into the queue by the edge that accepts its byte and is then loaded
// into the output register once out_ch can take it. Configuration (index 0
// header_entries, index 1 map_entries) is written through cfg_wr_en / cfg_index /
// cfg_data while the block is idle; QUEUE_DEPTH must be two or more.
module tagged_value_stream_decoder #(
	parameter int QUEUE_DEPTH = tvsd_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	tvsd_in_if.sink          in_ch,
	tvsd_out_if.source       out_ch
);

	// front to queue
	logic              push;
	tvsd_pkg::evt_t    push_evt;

	// queue to back
	logic              pop;
	tvsd_pkg::evt_t    head_evt;
	tvsd_pkg::q_stat_t q_stat;

	// front: tag decode, payload gathering, element count, stop after unknown tag
	tvsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_stat (q_stat),
		.push   (push),
		.evt    (push_evt)
	);

	// decouples the byte side from output backpressure
	tvsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_evt),
		.pop       (pop),
		.head      (head_evt),
		.stat      (q_stat)
	);

	// back: map window check, config registers, output register
	tvsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head_evt),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire
